// ----- rtl/core/pse_pkg.sv -----
// shared types, constants and fixed point helpers of the particle step unit
package pse_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_W        = 32;
    localparam int AXES          = 3;
    localparam int HMAG_W        = 32;
    localparam int MAG_W         = 31;
    localparam int SHIFT_W       = 5;
    localparam int NUM_W         = 62;
    localparam int SUM_W         = 64;
    localparam int LEN_W         = 32;
    localparam int DRAG_W        = 33;
    localparam int GAIN_W        = 31;
    localparam int PROD_W        = 64;
    localparam int SAT_W         = 66;
    localparam int SQRT_STAGES   = 32;
    localparam int DIV_STAGES    = 31;
    localparam int IDX_W         = 2;

    localparam logic [IDX_W-1:0] REG_STEER_GAIN = 2'd0;
    localparam logic [IDX_W-1:0] REG_DRAG_GAIN  = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIME_STEP  = 2'd2;

    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(32'h7FFF_FFFF);
    localparam logic signed [SAT_W-1:0] SAT_LO = ~SAT_HI;

    typedef struct packed {
        logic [GAIN_W-1:0] steer_gain;
        logic [GAIN_W-1:0] drag_gain;
        logic [WORD_W-1:0] time_step;
    } cfg_t;

    typedef struct packed {
        logic [AXES-1:0][WORD_W-1:0] new_pos;
        logic [AXES-1:0][WORD_W-1:0] vel;
        logic [AXES-1:0][DRAG_W-1:0] drag;
        logic [AXES-1:0]             h_neg;
        logic                        zero;
    } side_t;

    function automatic logic [WORD_W-1:0] mag32(input logic [WORD_W-1:0] v);
        return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
    endfunction

    function automatic logic [WORD_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
        logic [WORD_W-1:0] r;
        if (v > SAT_HI) begin
            r = SAT_HI[WORD_W-1:0];
        end else if (v < SAT_LO) begin
            r = SAT_LO[WORD_W-1:0];
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

    // magnitude product scaled down, truncated toward zero, sign applied
    function automatic logic signed [SAT_W-1:0] mulq_fin(input logic [PROD_W-1:0] prod,
                                                         input logic neg,
                                                         input int unsigned frac);
        logic [PROD_W-1:0]        p;
        logic signed [SAT_W-1:0]  v;
        p = prod >> frac;
        v = $signed({2'b00, p});
        return neg ? -v : v;
    endfunction

endpackage

// ----- rtl/core/particle_seek_euler_step_unit.sv -----
// One Euler step per particle: steering toward an attractor, linear drag and a signed time
// step, all in saturating Q16.16. A word is taken on every cycle in which the output is free
// or being taken, so the unit sustains one particle per cycle; each result passes through the
// 32-stage square root of the squared distance, the 31-stage quotient of the steering scale
// and five front and three back stages. A stall on the output holds the whole pipeline. The
// register port is always ready and ignores unknown indexes; registers are meant to change
// only while no word is in flight.
module particle_seek_euler_step_unit #(
    parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, target_x, target_y, target_z
    input  logic [9*pse_pkg::WORD_W-1:0] s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z
    output logic [6*pse_pkg::WORD_W-1:0] m_tdata,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pse_pkg::IDX_W-1:0]   cfg_index,
    input  logic [pse_pkg::WORD_W-1:0]  cfg_data
);

    localparam int AXES    = pse_pkg::AXES;
    localparam int VEC_W   = AXES * pse_pkg::WORD_W;
    localparam logic [pse_pkg::GAIN_W-1:0] STEER_RESET = pse_pkg::GAIN_W'(100 << FRAC_BITS);
    localparam logic [pse_pkg::GAIN_W-1:0] TENTH_RESET =
        pse_pkg::GAIN_W'(((1 << FRAC_BITS) + 5) / 10);
    localparam int PIPE_DEPTH = 5 + pse_pkg::SQRT_STAGES + pse_pkg::DIV_STAGES + 3;
    localparam int CNT_W      = $clog2(PIPE_DEPTH + 1);

    logic                                          en;
    pse_pkg::cfg_t                                 cfg_reg;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]          s_pos, s_vel, s_tgt;
    logic                                          f_valid;
    logic [pse_pkg::SUM_W-1:0]                     f_sum;
    logic [AXES-1:0][pse_pkg::NUM_W-1:0]           f_num;
    pse_pkg::side_t                                f_side;
    logic                                          r_valid;
    logic [pse_pkg::LEN_W-1:0]                     r_len;
    logic [AXES-1:0][pse_pkg::NUM_W-1:0]           r_num;
    pse_pkg::side_t                                r_side;
    logic                                          d_valid;
    logic [AXES-1:0][pse_pkg::MAG_W-1:0]           d_quot;
    pse_pkg::side_t                                d_side;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]          o_pos, o_vel;
    logic [CNT_W-1:0]                              count_reg, count_next;

    assign en        = !m_tvalid || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    assign s_pos = s_tdata[VEC_W-1:0];
    assign s_vel = s_tdata[2*VEC_W-1:VEC_W];
    assign s_tgt = s_tdata[3*VEC_W-1:2*VEC_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.steer_gain <= STEER_RESET;
            cfg_reg.drag_gain  <= TENTH_RESET;
            cfg_reg.time_step  <= pse_pkg::WORD_W'(TENTH_RESET);
        end else if (cfg_valid) begin
            case (cfg_index)
                pse_pkg::REG_STEER_GAIN: cfg_reg.steer_gain <= cfg_data[pse_pkg::GAIN_W-1:0];
                pse_pkg::REG_DRAG_GAIN:  cfg_reg.drag_gain  <= cfg_data[pse_pkg::GAIN_W-1:0];
                pse_pkg::REG_TIME_STEP:  cfg_reg.time_step  <= cfg_data;
                default: ;
            endcase
        end
    end

    pse_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_pos    (s_pos),
        .in_vel    (s_vel),
        .in_tgt    (s_tgt),
        .out_valid (f_valid),
        .out_sum   (f_sum),
        .out_num   (f_num),
        .out_side  (f_side)
    );

    pse_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_sum    (f_sum),
        .in_num    (f_num),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_len   (r_len),
        .out_num   (r_num),
        .out_side  (r_side)
    );

    pse_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .in_len    (r_len),
        .in_num    (r_num),
        .in_side   (r_side),
        .out_valid (d_valid),
        .out_quot  (d_quot),
        .out_side  (d_side)
    );

    pse_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cfg       (cfg_reg),
        .in_valid  (d_valid),
        .in_quot   (d_quot),
        .in_side   (d_side),
        .out_valid (m_tvalid),
        .out_pos   (o_pos),
        .out_vel   (o_vel)
    );

    assign m_tdata = {o_vel, o_pos};

    // words in flight
    always_comb begin
        count_next = count_reg;
        if (s_tvalid && s_tready) begin
            count_next = count_next + CNT_W'(1);
        end
        if (m_tvalid && m_tready) begin
            count_next = count_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    a_inflight_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(PIPE_DEPTH))
        else $error("more words in flight than pipeline stages");

    a_out_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (count_reg != '0))
        else $error("output word without a matching input word");

endmodule

// ----- rtl/core/pse_front.sv -----
// front stages: difference, normalizing, squares and their sum, steering numerators, position update, drag
module pse_front #(
    parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
    input  logic                                              aclk,
    input  logic                                              aresetn,
    input  logic                                              en,
    input  pse_pkg::cfg_t                                     cfg,
    input  logic                                              in_valid,
    input  logic [pse_pkg::AXES-1:0][pse_pkg::WORD_W-1:0]     in_pos,
    input  logic [pse_pkg::AXES-1:0][pse_pkg::WORD_W-1:0]     in_vel,
    input  logic [pse_pkg::AXES-1:0][pse_pkg::WORD_W-1:0]     in_tgt,
    output logic                                              out_valid,
    output logic [pse_pkg::SUM_W-1:0]                         out_sum,
    output logic [pse_pkg::AXES-1:0][pse_pkg::NUM_W-1:0]      out_num,
    output pse_pkg::side_t                                    out_side
);

    localparam int AXES = pse_pkg::AXES;
    localparam logic signed [pse_pkg::SAT_W-1:0] DRAG_HI = pse_pkg::SAT_W'(33'h0_FFFF_FFFF);
    localparam logic signed [pse_pkg::SAT_W-1:0] DRAG_LO = ~DRAG_HI;

    function automatic logic [pse_pkg::DRAG_W-1:0] clamp33(
        input logic signed [pse_pkg::SAT_W-1:0] t);
        logic [pse_pkg::DRAG_W-1:0] r;
        if (t > DRAG_HI) begin
            r = DRAG_HI[pse_pkg::DRAG_W-1:0];
        end else if (t < DRAG_LO) begin
            r = DRAG_LO[pse_pkg::DRAG_W-1:0];
        end else begin
            r = t[pse_pkg::DRAG_W-1:0];
        end
        return r;
    endfunction

    // stage a
    logic                                        a_valid_reg;
    logic [AXES-1:0][pse_pkg::HMAG_W-1:0]        a_hm_reg, a_hm_next;
    logic [AXES-1:0]                             a_hneg_reg, a_hneg_next;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]        a_vm_reg, a_vm_next;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]        a_pos_reg, a_vel_reg;
    // stage b
    logic                                        b_valid_reg;
    logic [AXES-1:0][pse_pkg::HMAG_W-1:0]        b_hm_reg;
    logic [AXES-1:0]                             b_hneg_reg;
    logic [pse_pkg::SHIFT_W-1:0]                 b_shift_reg, b_shift_next;
    logic                                        b_halve_reg, b_halve_next;
    logic                                        b_zero_reg, b_zero_next;
    logic [AXES-1:0][pse_pkg::PROD_W-1:0]        b_pv_reg, b_pv_next;
    logic [AXES-1:0][pse_pkg::PROD_W-1:0]        b_pd_reg, b_pd_next;
    logic [AXES-1:0]                             b_pvneg_reg, b_pvneg_next;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]        b_pos_reg, b_vel_reg;
    // stage c
    logic                                        c_valid_reg;
    logic [AXES-1:0][pse_pkg::MAG_W-1:0]         c_hn_reg, c_hn_next;
    pse_pkg::side_t                              c_side_reg, c_side_next;
    logic [pse_pkg::MAG_W-1:0]                   c_or;
    // stage d
    logic                                        d_valid_reg;
    logic [AXES-1:0][pse_pkg::NUM_W-1:0]         d_sq_reg, d_sq_next;
    logic [AXES-1:0][pse_pkg::NUM_W-1:0]         d_num_reg, d_num_next;
    pse_pkg::side_t                              d_side_reg;
    // stage e
    logic                                        e_valid_reg;
    logic [pse_pkg::SUM_W-1:0]                   e_sum_reg, e_sum_next;
    logic [AXES-1:0][pse_pkg::NUM_W-1:0]         e_num_reg;
    pse_pkg::side_t                              e_side_reg;

    logic [pse_pkg::WORD_W-1:0]                  tsm;
    logic [pse_pkg::HMAG_W-1:0]                  orw;
    logic [pse_pkg::SHIFT_W-1:0]                 msb;

    assign tsm = pse_pkg::mag32(cfg.time_step);

    always_comb begin
        logic signed [pse_pkg::WORD_W:0] h;
        for (int i = 0; i < AXES; i++) begin
            h = $signed({in_tgt[i][pse_pkg::WORD_W-1], in_tgt[i]})
              - $signed({in_pos[i][pse_pkg::WORD_W-1], in_pos[i]});
            a_hneg_next[i] = h[pse_pkg::WORD_W];
            a_hm_next[i]   = h[pse_pkg::WORD_W] ? pse_pkg::HMAG_W'(-h)
                                                : pse_pkg::HMAG_W'(h);
            a_vm_next[i]   = pse_pkg::mag32(in_vel[i]);
        end
    end

    // leading one of the or of all magnitudes equals that of the largest
    always_comb begin
        orw = a_hm_reg[0] | a_hm_reg[1] | a_hm_reg[2];
        msb = '0;
        for (int b = 0; b < pse_pkg::MAG_W; b++) begin
            if (orw[b]) begin
                msb = pse_pkg::SHIFT_W'(b);
            end
        end
        b_shift_next = pse_pkg::SHIFT_W'(pse_pkg::MAG_W - 1) - msb;
        b_halve_next = orw[pse_pkg::HMAG_W-1];
        b_zero_next  = (orw == '0);
        for (int i = 0; i < AXES; i++) begin
            b_pv_next[i]    = pse_pkg::PROD_W'(a_vm_reg[i]) * pse_pkg::PROD_W'(tsm);
            b_pd_next[i]    = pse_pkg::PROD_W'(a_vm_reg[i])
                            * pse_pkg::PROD_W'(cfg.drag_gain);
            b_pvneg_next[i] = a_vel_reg[i][pse_pkg::WORD_W-1]
                            ^ cfg.time_step[pse_pkg::WORD_W-1];
        end
    end

    always_comb begin
        logic [pse_pkg::HMAG_W-1:0]  hm_sh;
        logic [pse_pkg::HMAG_W-1:0]  hm_half;
        logic signed [pse_pkg::SAT_W-1:0] np;
        c_side_next.zero  = b_zero_reg;
        c_side_next.h_neg = b_hneg_reg;
        c_side_next.vel   = b_vel_reg;
        for (int i = 0; i < AXES; i++) begin
            hm_sh   = b_hm_reg[i] << b_shift_reg;
            hm_half = b_hm_reg[i] >> 1;
            c_hn_next[i] = b_halve_reg ? hm_half[pse_pkg::MAG_W-1:0]
                                       : hm_sh[pse_pkg::MAG_W-1:0];
            np = pse_pkg::SAT_W'($signed(b_pos_reg[i]))
               + pse_pkg::mulq_fin(b_pv_reg[i], b_pvneg_reg[i], FRAC_BITS);
            c_side_next.new_pos[i] = pse_pkg::sat32(np);
            c_side_next.drag[i] = clamp33(pse_pkg::mulq_fin(b_pd_reg[i],
                                          b_vel_reg[i][pse_pkg::WORD_W-1], FRAC_BITS));
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            d_sq_next[i]  = pse_pkg::NUM_W'(c_hn_reg[i]) * pse_pkg::NUM_W'(c_hn_reg[i]);
            d_num_next[i] = pse_pkg::NUM_W'(cfg.steer_gain) * pse_pkg::NUM_W'(c_hn_reg[i]);
        end
        e_sum_next = pse_pkg::SUM_W'(d_sq_reg[0]) + pse_pkg::SUM_W'(d_sq_reg[1])
                   + pse_pkg::SUM_W'(d_sq_reg[2]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_hm_reg    <= a_hm_next;
            a_hneg_reg  <= a_hneg_next;
            a_vm_reg    <= a_vm_next;
            a_pos_reg   <= in_pos;
            a_vel_reg   <= in_vel;
            b_hm_reg    <= a_hm_reg;
            b_hneg_reg  <= a_hneg_reg;
            b_shift_reg <= b_shift_next;
            b_halve_reg <= b_halve_next;
            b_zero_reg  <= b_zero_next;
            b_pv_reg    <= b_pv_next;
            b_pd_reg    <= b_pd_next;
            b_pvneg_reg <= b_pvneg_next;
            b_pos_reg   <= a_pos_reg;
            b_vel_reg   <= a_vel_reg;
            c_hn_reg    <= c_hn_next;
            c_side_reg  <= c_side_next;
            d_sq_reg    <= d_sq_next;
            d_num_reg   <= d_num_next;
            d_side_reg  <= c_side_reg;
            e_sum_reg   <= e_sum_next;
            e_num_reg   <= d_num_reg;
            e_side_reg  <= d_side_reg;
        end
    end

    assign out_valid = e_valid_reg;
    assign out_sum   = e_sum_reg;
    assign out_num   = e_num_reg;
    assign out_side  = e_side_reg;

    assign c_or = c_hn_reg[0] | c_hn_reg[1] | c_hn_reg[2];

    // a nonzero offset leaves the largest magnitude with its top bit set
    a_norm_top: assert property (@(posedge aclk) disable iff (!aresetn)
        (c_valid_reg && !c_side_reg.zero) |-> c_or[pse_pkg::MAG_W-1])
        else $error("normalized offset lacks its top bit");

endmodule

// ----- rtl/core/pse_isqrt.sv -----
// pipelined integer square root, one result bit per stage
module pse_isqrt (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [pse_pkg::SUM_W-1:0]                     in_sum,
    input  logic [pse_pkg::AXES-1:0][pse_pkg::NUM_W-1:0]  in_num,
    input  pse_pkg::side_t                                in_side,
    output logic                                          out_valid,
    output logic [pse_pkg::LEN_W-1:0]                     out_len,
    output logic [pse_pkg::AXES-1:0][pse_pkg::NUM_W-1:0]  out_num,
    output pse_pkg::side_t                                out_side
);

    localparam int N = pse_pkg::SQRT_STAGES;

    logic                                          v_reg    [N];
    logic [pse_pkg::SUM_W-1:0]                     x_reg    [N];
    logic [pse_pkg::SUM_W-1:0]                     r_reg    [N];
    logic [pse_pkg::AXES-1:0][pse_pkg::NUM_W-1:0]  num_reg  [N];
    pse_pkg::side_t                                side_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                                          v_in;
        logic [pse_pkg::SUM_W-1:0]                     x_in, r_in;
        logic [pse_pkg::AXES-1:0][pse_pkg::NUM_W-1:0]  num_in;
        pse_pkg::side_t                                side_in;
        logic [pse_pkg::SUM_W-1:0]                     bit_w, trial, x_next, r_next;

        if (g == 0) begin : g_first
            assign v_in    = in_valid;
            assign x_in    = in_sum;
            assign r_in    = '0;
            assign num_in  = in_num;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[g-1];
            assign x_in    = x_reg[g-1];
            assign r_in    = r_reg[g-1];
            assign num_in  = num_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign bit_w = pse_pkg::SUM_W'(1) << (2 * (N - 1 - g));
        assign trial = r_in + bit_w;

        always_comb begin
            if (x_in >= trial) begin
                x_next = x_in - trial;
                r_next = (r_in >> 1) + bit_w;
            end else begin
                x_next = x_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[g]    <= x_next;
                r_reg[g]    <= r_next;
                num_reg[g]  <= num_in;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_len   = r_reg[N-1][pse_pkg::LEN_W-1:0];
    assign out_num   = num_reg[N-1];
    assign out_side  = side_reg[N-1];

    // leftover of the root lies within twice the root
    a_root_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        v_reg[N-1] |-> (x_reg[N-1] <= (r_reg[N-1] << 1)))
        else $error("square root leftover out of range");

endmodule

// ----- rtl/core/pse_div.sv -----
// pipelined restoring dividers, one quotient bit per stage, one per axis
module pse_div (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  logic                                          in_valid,
    input  logic [pse_pkg::LEN_W-1:0]                     in_len,
    input  logic [pse_pkg::AXES-1:0][pse_pkg::NUM_W-1:0]  in_num,
    input  pse_pkg::side_t                                in_side,
    output logic                                          out_valid,
    output logic [pse_pkg::AXES-1:0][pse_pkg::MAG_W-1:0]  out_quot,
    output pse_pkg::side_t                                out_side
);

    localparam int N    = pse_pkg::DIV_STAGES;
    localparam int AXES = pse_pkg::AXES;
    localparam int T_W  = pse_pkg::NUM_W + 1;

    logic                                          v_reg    [N];
    logic [pse_pkg::LEN_W-1:0]                     len_reg  [N];
    logic [AXES-1:0][pse_pkg::NUM_W-1:0]           rem_reg  [N];
    logic [AXES-1:0][pse_pkg::MAG_W-1:0]           quo_reg  [N];
    pse_pkg::side_t                                side_reg [N];

    for (genvar g = 0; g < N; g++) begin : g_stage
        logic                                  v_in;
        logic [pse_pkg::LEN_W-1:0]             len_in;
        logic [AXES-1:0][pse_pkg::NUM_W-1:0]   rem_in, rem_next;
        logic [AXES-1:0][pse_pkg::MAG_W-1:0]   quo_in, quo_next;
        pse_pkg::side_t                        side_in;
        logic [T_W-1:0]                        dsh;

        if (g == 0) begin : g_first
            assign v_in    = in_valid;
            assign len_in  = in_len;
            assign rem_in  = in_num;
            assign quo_in  = '0;
            assign side_in = in_side;
        end else begin : g_rest
            assign v_in    = v_reg[g-1];
            assign len_in  = len_reg[g-1];
            assign rem_in  = rem_reg[g-1];
            assign quo_in  = quo_reg[g-1];
            assign side_in = side_reg[g-1];
        end

        assign dsh = T_W'(len_in) << (N - 1 - g);

        always_comb begin
            for (int i = 0; i < AXES; i++) begin
                if (T_W'(rem_in[i]) >= dsh) begin
                    rem_next[i] = pse_pkg::NUM_W'(T_W'(rem_in[i]) - dsh);
                    quo_next[i] = quo_in[i] | (pse_pkg::MAG_W'(1) << (N - 1 - g));
                end else begin
                    rem_next[i] = rem_in[i];
                    quo_next[i] = quo_in[i];
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                len_reg[g]  <= len_in;
                rem_reg[g]  <= rem_next;
                quo_reg[g]  <= quo_next;
                side_reg[g] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quot  = quo_reg[N-1];
    assign out_side  = side_reg[N-1];

    // the quotient fits, so every remainder ends below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (v_reg[N-1] && (len_reg[N-1] != '0)) |->
        ((rem_reg[N-1][0] < pse_pkg::NUM_W'(len_reg[N-1]))
      && (rem_reg[N-1][1] < pse_pkg::NUM_W'(len_reg[N-1]))
      && (rem_reg[N-1][2] < pse_pkg::NUM_W'(len_reg[N-1]))))
        else $error("divider remainder not below divisor");

endmodule

// ----- rtl/core/pse_back.sv -----
// back stages: acceleration, velocity update and output register
module pse_back #(
    parameter int FRAC_BITS = pse_pkg::FRAC_BITS_DEF
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          en,
    input  pse_pkg::cfg_t                                 cfg,
    input  logic                                          in_valid,
    input  logic [pse_pkg::AXES-1:0][pse_pkg::MAG_W-1:0]  in_quot,
    input  pse_pkg::side_t                                in_side,
    output logic                                          out_valid,
    output logic [pse_pkg::AXES-1:0][pse_pkg::WORD_W-1:0] out_pos,
    output logic [pse_pkg::AXES-1:0][pse_pkg::WORD_W-1:0] out_vel
);

    localparam int AXES = pse_pkg::AXES;

    logic                                    p_valid_reg;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]    p_acc_reg, p_acc_next;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]    p_pos_reg, p_vel_reg;
    logic                                    q_valid_reg;
    logic [AXES-1:0][pse_pkg::PROD_W-1:0]    q_prod_reg, q_prod_next;
    logic [AXES-1:0]                         q_neg_reg, q_neg_next;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]    q_pos_reg, q_vel_reg;
    logic                                    o_valid_reg;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]    o_pos_reg;
    logic [AXES-1:0][pse_pkg::WORD_W-1:0]    o_vel_reg, o_vel_next;
    logic [pse_pkg::WORD_W-1:0]              tsm;

    assign tsm = pse_pkg::mag32(cfg.time_step);

    always_comb begin
        logic signed [pse_pkg::SAT_W-1:0] qv, steer, acc;
        for (int i = 0; i < AXES; i++) begin
            qv    = $signed(pse_pkg::SAT_W'(in_quot[i]));
            steer = in_side.zero ? '0 : (in_side.h_neg[i] ? -qv : qv);
            acc   = steer - pse_pkg::SAT_W'($signed(in_side.drag[i]));
            p_acc_next[i] = pse_pkg::sat32(acc);
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            q_prod_next[i] = pse_pkg::PROD_W'(pse_pkg::mag32(p_acc_reg[i]))
                           * pse_pkg::PROD_W'(tsm);
            q_neg_next[i]  = p_acc_reg[i][pse_pkg::WORD_W-1]
                           ^ cfg.time_step[pse_pkg::WORD_W-1];
        end
    end

    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            o_vel_next[i] = pse_pkg::sat32(pse_pkg::SAT_W'($signed(q_vel_reg[i]))
                          + pse_pkg::mulq_fin(q_prod_reg[i], q_neg_reg[i], FRAC_BITS));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= in_valid;
            q_valid_reg <= p_valid_reg;
            o_valid_reg <= q_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_acc_reg  <= p_acc_next;
            p_pos_reg  <= in_side.new_pos;
            p_vel_reg  <= in_side.vel;
            q_prod_reg <= q_prod_next;
            q_neg_reg  <= q_neg_next;
            q_pos_reg  <= p_pos_reg;
            q_vel_reg  <= p_vel_reg;
            o_pos_reg  <= q_pos_reg;
            o_vel_reg  <= o_vel_next;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_pos   = o_pos_reg;
    assign out_vel   = o_vel_reg;

endmodule

// ----- dv/testbench.sv -----
// testbench of the particle step unit: directed and random particles checked against a local model
module testbench;

    localparam int FB = pse_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 71;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [9*pse_pkg::WORD_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [6*pse_pkg::WORD_W-1:0] m_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pse_pkg::IDX_W-1:0] cfg_index = '0;
    logic [pse_pkg::WORD_W-1:0] cfg_data = '0;

    particle_seek_euler_step_unit u_top (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // local copy of the registers
    longint unsigned steer_gain_q = 64'd100 << FB;
    longint unsigned drag_gain_q = ((64'd1 << FB) + 5) / 10;
    longint time_step_q = ((64'd1 << FB) + 5) / 10;

    logic [6*pse_pkg::WORD_W-1:0] step_results_q[$];
    int errors = 0;
    int particles_sent = 0;
    int steps_checked = 0;
    bit idle_enable = 1'b1;
    bit hold_output = 1'b0;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fixmul(longint a, longint b);
        longint unsigned ma, mb, p;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        p = (ma * mb) >> FB;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [6*pse_pkg::WORD_W-1:0] euler_step(
        logic [9*pse_pkg::WORD_W-1:0] d);
        longint p[3], v[3], h[3], st, acc;
        longint unsigned hm[3], m, len, q;
        logic [6*pse_pkg::WORD_W-1:0] r;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(d[i*32 +: 32]));
            v[i] = longint'($signed(d[(3+i)*32 +: 32]));
            h[i] = longint'($signed(d[(6+i)*32 +: 32])) - p[i];
            hm[i] = h[i] < 0 ? -h[i] : h[i];
            if (hm[i] > m) m = hm[i];
        end
        if (m >= (64'd1 << 31)) begin
            for (int i = 0; i < 3; i++) hm[i] >>= 1;
        end else if (m != 0) begin
            while (m < (64'd1 << 30)) begin
                m <<= 1;
                for (int i = 0; i < 3; i++) hm[i] <<= 1;
            end
        end
        len = int_sqrt(hm[0]*hm[0] + hm[1]*hm[1] + hm[2]*hm[2]);
        for (int i = 0; i < 3; i++) begin
            st = 0;
            if (len != 0) begin
                q = (steer_gain_q * hm[i]) / len;
                st = h[i] < 0 ? -longint'(q) : longint'(q);
            end
            acc = clamp32(st - fixmul(drag_gain_q, v[i]));
            r[i*32 +: 32] = 32'(clamp32(p[i] + fixmul(v[i], time_step_q)));
            r[(3+i)*32 +: 32] = 32'(clamp32(v[i] + fixmul(acc, time_step_q)));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch: %s", what);
    endtask

    task automatic pause_cycles(int n);
        repeat (n) @(negedge aclk);
    endtask

    task automatic send_particle(logic [9*pse_pkg::WORD_W-1:0] d);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            pause_cycles($urandom_range(1, 8));
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        step_results_q.push_back(euler_step(d));
        particles_sent++;
        @(negedge aclk);
    endtask

    task automatic end_burst;
        s_tvalid <= 1'b0;
    endtask

    task automatic drain;
        int n;
        n = 0;
        while (step_results_q.size() != 0 && n < 100000) begin
            @(negedge aclk);
            n++;
        end
        pause_cycles(LATENCY + 10);
    endtask

    task automatic write_reg(logic [pse_pkg::IDX_W-1:0] idx, logic [pse_pkg::WORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            pse_pkg::REG_STEER_GAIN: steer_gain_q = val[30:0];
            pse_pkg::REG_DRAG_GAIN: drag_gain_q = val[30:0];
            pse_pkg::REG_TIME_STEP: time_step_q = longint'($signed(val));
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 1 << 20)
                                           : -$urandom_range(0, 1 << 20);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [9*pse_pkg::WORD_W-1:0] rand_particle();
        logic [9*pse_pkg::WORD_W-1:0] d;
        for (int i = 0; i < 9; i++) d[i*32 +: 32] = rand_word();
        if ($urandom_range(0, 9) == 0) d[6*32 +: 96] = d[0 +: 96];
        return d;
    endfunction

    function automatic logic [9*pse_pkg::WORD_W-1:0] fill(logic [31:0] p, logic [31:0] v,
                                                          logic [31:0] t);
        return {t, t, t, v, v, v, p, p, p};
    endfunction

    // result checker
    always @(posedge aclk) begin
        logic [6*pse_pkg::WORD_W-1:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (step_results_q.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = step_results_q.pop_front();
                steps_checked++;
                for (int i = 0; i < 6; i++)
                    if (m_tdata[i*32 +: 32] !== want[i*32 +: 32])
                        report_mismatch($sformatf("field %0d got %h want %h", i,
                                        m_tdata[i*32 +: 32], want[i*32 +: 32]));
            end
        end
    end

    // output stall driver
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_output) begin
                m_tready <= 1'b0;
            end else if (idle_enable && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                pause_cycles($urandom_range(1, 8) - 1);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed;
        send_particle(fill(32'h0, 32'h0, 32'h0));
        send_particle(fill(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
        send_particle(fill(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
        send_particle(fill(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000));
        send_particle(fill(32'h1234_5678, 32'h7FFF_FFFF, 32'h1234_5678));
        send_particle(fill(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0000));
        send_particle({32'h0, 32'h0, 32'h0001_0000, 96'h0, 96'h0});
        send_particle({32'h0, 32'h7FFF_FFFF, 32'h0, {3{32'h8000_0000}}, 96'h0});
        send_particle({{3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}, {3{32'hFFFF_FFFF}}});
        end_burst();
        drain();
    endtask

    task automatic test_extreme_registers;
        write_reg(pse_pkg::REG_STEER_GAIN, 32'h7FFF_FFFF);
        write_reg(pse_pkg::REG_DRAG_GAIN, 32'h7FFF_FFFF);
        write_reg(pse_pkg::REG_TIME_STEP, 32'h7FFF_FFFF);
        for (int i = 0; i < 6; i++) send_particle(rand_particle());
        end_burst();
        drain();
        write_reg(pse_pkg::REG_TIME_STEP, 32'h8000_0000);
        for (int i = 0; i < 6; i++) send_particle(rand_particle());
        end_burst();
        drain();
        write_reg(pse_pkg::REG_STEER_GAIN, 32'h0);
        write_reg(pse_pkg::REG_DRAG_GAIN, 32'h0);
        write_reg(pse_pkg::REG_TIME_STEP, 32'h0);
        write_reg(2'd3, 32'hDEAD_BEEF);
        for (int i = 0; i < 6; i++) send_particle(rand_particle());
        end_burst();
        drain();
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(pse_pkg::REG_STEER_GAIN,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 24));
            write_reg(pse_pkg::REG_DRAG_GAIN,
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 17));
            write_reg(pse_pkg::REG_TIME_STEP, $urandom_range(0, 3) == 0 ? $urandom
                      : ($urandom_range(0, 1) ? $urandom_range(0, 1 << 17)
                                             : -$urandom_range(0, 1 << 17)));
            for (int i = 0; i < 130; i++) send_particle(rand_particle());
            end_burst();
            drain();
        end
    endtask

    task automatic test_backpressure;
        hold_output = 1'b1;
        fork
            begin
                pause_cycles(300);
                hold_output = 1'b0;
            end
            for (int i = 0; i < 100; i++) send_particle(rand_particle());
        join
        end_burst();
        drain();
    endtask

    task automatic test_full_rate;
        idle_enable = 1'b0;
        write_reg(pse_pkg::REG_TIME_STEP, -32'sd6554);
        for (int i = 0; i < 60; i++) send_particle(rand_particle());
        end_burst();
        drain();
    endtask

    initial begin
        pause_cycles(7);
        aresetn <= 1'b1;
        pause_cycles(2);
        test_directed();
        test_extreme_registers();
        test_random_phases();
        test_backpressure();
        test_full_rate();
        $display("%0d particles sent, %0d steps checked, under register extremes,",
                 particles_sent, steps_checked);
        $display("random gains and time steps, output stalls and a long output hold");
        if (errors == 0 && step_results_q.size() == 0) begin
            $display("** particle_seek_euler_step_unit: PASSED **");
        end else begin
            $display("** particle_seek_euler_step_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("** particle_seek_euler_step_unit: FAILED **");
        $finish;
    end
endmodule

// ----- particle_seek_euler_step_unit.f -----
rtl/core/pse_pkg.sv
rtl/core/pse_front.sv
rtl/core/pse_isqrt.sv
rtl/core/pse_div.sv
rtl/core/pse_back.sv
rtl/core/particle_seek_euler_step_unit.sv
dv/testbench.sv
